/* hdl/aarm_pkg.sv */
// package for the axis-angle rotation matrix block: types, constants, arctangent table
package aarm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 12;
    localparam int ATAN_ENTRIES     = 24;
    localparam int WORK_BITS        = 30;
    localparam int XY_W             = 33;
    localparam int Z_W              = 26;
    localparam int ANG_W            = 17;
    localparam int AXIS_W           = 16;
    localparam int OUT_W            = 24;

    localparam logic signed [ANG_W-1:0] ANG_FULL   = 17'sd46080;
    localparam logic signed [ANG_W-1:0] ANG_HALF   = 17'sd23040;
    localparam logic signed [ANG_W-1:0] ANG_QUART  = 17'sd11520;
    localparam logic signed [ANG_W-1:0] ANG_3QUART = 17'sd34560;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic signed [ANG_W-1:0]  angle_deg;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
    } t_out;

    // data handed from one cordic cell to the next
    typedef struct packed {
        logic                     vld;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic                     neg;
        logic signed [AXIS_W-1:0] nx;
        logic signed [AXIS_W-1:0] ny;
        logic signed [AXIS_W-1:0] nz;
    } t_cell;

    function automatic logic signed [Z_W-1:0] atan_lut(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0: v = 26'sd2949120;   1: v = 26'sd1740967;  2: v = 26'sd919879;
            3: v = 26'sd466945;    4: v = 26'sd234379;   5: v = 26'sd117304;
            6: v = 26'sd58666;     7: v = 26'sd29335;    8: v = 26'sd14668;
            9: v = 26'sd7334;      10: v = 26'sd3667;    11: v = 26'sd1833;
            12: v = 26'sd917;      13: v = 26'sd458;     14: v = 26'sd229;
            15: v = 26'sd115;      16: v = 26'sd57;      17: v = 26'sd29;
            18: v = 26'sd14;       19: v = 26'sd7;       20: v = 26'sd4;
            21: v = 26'sd2;        22: v = 26'sd1;       default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/axis_angle_rotation_matrix.sv */
// top level: angle reduction, cordic cell chain, matrix stages, output skid
//
// Rodrigues rotation matrix generator.
// Input channel i_valid/o_ready carries angle (1/128 degree) and a Q3.12 axis.
// Output channel o_valid/i_ready carries the nine Q.12 entries of the 3x3
// rotation part, saturated to 24 bits, one result per request, in order.
// Pipeline: one reduction stage, CORDIC_STEPS cordic cells, three matrix
// stages and the output buffer register.
// Throughput is one request per cycle while o_ready is high; each cordic
// cell takes one micro-rotation and hands x, y and residual angle to its neighbor.
// When the receiver stalls, the pipeline keeps moving until its last stage
// holds a result and the two-entry output skid buffer is full; the buffer
// keeps o_ready free of any path from i_ready and lets a new request enter
// while a finished result waits. Synchronous active-low reset clears all
// valid flags; no data is lost or invented across stalls. Nothing needs configuring.
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  aarm_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output aarm_pkg::t_out o_data
);
    import aarm_pkg::*;

    logic en;
    logic pipe_vld;
    t_out pipe_m;

    // skid buffer: two entries
    t_out r_b0, r_b1;
    logic [1:0] r_cnt;

    // pipeline advances unless its last stage holds a result that cannot drop
    assign en      = !(pipe_vld && r_cnt == 2'd2);
    assign o_ready = en;

    // angle reduction stage
    logic signed [ANG_W:0] n_r;
    logic signed [ANG_W:0] full_x;
    logic n_neg;
    t_cell r0;

    assign full_x = {{1{ANG_FULL[ANG_W-1]}}, ANG_FULL};

    always_comb begin
        n_r = {i_data.angle_deg[ANG_W-1], i_data.angle_deg};
        if (n_r < 0) n_r = n_r + full_x;
        if (n_r < 0) n_r = n_r + full_x;
        if (n_r >= full_x) n_r = n_r - full_x;
        n_neg = 1'b0;
        if (n_r > 18'(ANG_QUART) && n_r < 18'(ANG_3QUART)) begin
            n_r = n_r - 18'(ANG_HALF);
            n_neg = 1'b1;
        end else if (n_r >= 18'(ANG_3QUART)) begin
            n_r = n_r - full_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0.vld <= 1'b0;
        end else if (en) begin
            r0.vld <= i_valid;
        end
        if (en) begin
            r0.x   <= CORDIC_GAIN;
            r0.y   <= '0;
            r0.z   <= Z_W'(n_r) <<< 9;
            r0.neg <= n_neg;
            r0.nx  <= i_data.axis_x;
            r0.ny  <= i_data.axis_y;
            r0.nz  <= i_data.axis_z;
        end
    end

    t_cell chain [CORDIC_STEPS+1];
    assign chain[0] = r0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        aarm_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_d(chain[g]), .o_q(chain[g+1])
        );
    end

    aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_d(chain[CORDIC_STEPS]), .o_vld(pipe_vld), .o_m(pipe_m)
    );

    logic push, pop;
    assign push = pipe_vld && en;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (pop) begin
            r_b0 <= (r_cnt == 2'd2) ? r_b1 : pipe_m;
        end else if (push && r_cnt == 2'd0) begin
            r_b0 <= pipe_m;
        end
        if (push && ((r_cnt == 2'd1 && !pop) || (r_cnt == 2'd2))) begin
            r_b1 <= pipe_m;
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_b0;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("skid count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && pipe_vld) |-> !o_ready) else $error("accept while full");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result changed under stall");
`endif
endmodule

/* hdl/aarm_cell.sv */
// one cordic micro-rotation cell with its pipeline register
module aarm_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  aarm_pkg::t_cell i_d,
    output aarm_pkg::t_cell o_q
);
    import aarm_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_lut(STEP);

    t_cell r_q, n_q;

    always_comb begin
        n_q = i_d;
        if (i_d.z >= 0) begin
            n_q.x = i_d.x - (i_d.y >>> STEP);
            n_q.y = i_d.y + (i_d.x >>> STEP);
            n_q.z = i_d.z - ATAN;
        end else begin
            n_q.x = i_d.x + (i_d.y >>> STEP);
            n_q.y = i_d.y - (i_d.x >>> STEP);
            n_q.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q.vld <= n_q.vld;
        end
        if (i_en) begin
            r_q.x   <= n_q.x;
            r_q.y   <= n_q.y;
            r_q.z   <= n_q.z;
            r_q.neg <= n_q.neg;
            r_q.nx  <= n_q.nx;
            r_q.ny  <= n_q.ny;
            r_q.nz  <= n_q.nz;
        end
    end

    assign o_q = r_q;
endmodule

/* hdl/aarm_matrix.sv */
// matrix stages: round sine/cosine, form products, round and saturate entries
module aarm_matrix #(
    parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  aarm_pkg::t_cell i_d,
    output logic            o_vld,
    output aarm_pkg::t_out  o_m
);
    import aarm_pkg::*;

    localparam int SH  = WORK_BITS - FRAC_BITS;
    localparam int CS_W = XY_W;
    localparam int SC_W = FRAC_BITS + 3;
    localparam int P_W = 2 * AXIS_W;
    localparam int Q_W = P_W + SC_W;
    localparam int A_W = 72;
    localparam int RS  = 2 * FRAC_BITS;

    // stage a: sin/cos rounding and axis products
    logic                    r_va, r_vb;
    logic signed [SC_W-1:0]  r_c, r_s, r_omc;
    logic signed [P_W-1:0]   r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [AXIS_W-1:0] r_nx, r_ny, r_nz;
    logic signed [CS_W-1:0]  n_c, n_s;

    always_comb begin
        n_c = (i_d.x + (CS_W'(1) <<< (SH - 1))) >>> SH;
        n_s = (i_d.y + (CS_W'(1) <<< (SH - 1))) >>> SH;
        if (i_d.neg) begin
            n_c = -n_c;
            n_s = -n_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_d.vld;
            r_vb <= r_va;
        end
        if (i_en) begin
            r_c   <= SC_W'(n_c);
            r_s   <= SC_W'(n_s);
            r_omc <= SC_W'((CS_W'(1) <<< FRAC_BITS) - n_c);
            r_pxx <= i_d.nx * i_d.nx;
            r_pyy <= i_d.ny * i_d.ny;
            r_pzz <= i_d.nz * i_d.nz;
            r_pxy <= i_d.nx * i_d.ny;
            r_pxz <= i_d.nx * i_d.nz;
            r_pyz <= i_d.ny * i_d.nz;
            r_nx  <= i_d.nx;
            r_ny  <= i_d.ny;
            r_nz  <= i_d.nz;
        end
    end

    // stage b: second products
    logic signed [A_W-1:0] r_qxx, r_qyy, r_qzz, r_qxy, r_qxz, r_qyz;
    logic signed [A_W-1:0] r_sx, r_sy, r_sz, r_cd;
    logic signed [Q_W-1:0] n_qxx, n_qyy, n_qzz, n_qxy, n_qxz, n_qyz;
    logic signed [P_W-1:0] n_sx, n_sy, n_sz;

    always_comb begin
        n_qxx = r_pxx * r_omc;
        n_qyy = r_pyy * r_omc;
        n_qzz = r_pzz * r_omc;
        n_qxy = r_pxy * r_omc;
        n_qxz = r_pxz * r_omc;
        n_qyz = r_pyz * r_omc;
        n_sx  = r_nx * r_s;
        n_sy  = r_ny * r_s;
        n_sz  = r_nz * r_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qxx <= A_W'(n_qxx);
            r_qyy <= A_W'(n_qyy);
            r_qzz <= A_W'(n_qzz);
            r_qxy <= A_W'(n_qxy);
            r_qxz <= A_W'(n_qxz);
            r_qyz <= A_W'(n_qyz);
            r_sx  <= A_W'(n_sx) <<< FRAC_BITS;
            r_sy  <= A_W'(n_sy) <<< FRAC_BITS;
            r_sz  <= A_W'(n_sz) <<< FRAC_BITS;
            r_cd  <= A_W'(r_c) <<< RS;
        end
    end

    function automatic logic signed [OUT_W-1:0] fin(input logic signed [A_W-1:0] acc);
        logic signed [A_W-1:0] v;
        v = (acc + (A_W'(1) <<< (RS - 1))) >>> RS;
        if (v > A_W'(8388607)) return OUT_W'(8388607);
        if (v < -A_W'(8388608)) return OUT_W'(-8388608);
        return v[OUT_W-1:0];
    endfunction

    t_out r_m;
    logic r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vb;
        end
        if (i_en) begin
            r_m.m00 <= fin(r_qxx + r_cd);
            r_m.m01 <= fin(r_qxy - r_sz);
            r_m.m02 <= fin(r_qxz + r_sy);
            r_m.m10 <= fin(r_qxy + r_sz);
            r_m.m11 <= fin(r_qyy + r_cd);
            r_m.m12 <= fin(r_qyz - r_sx);
            r_m.m20 <= fin(r_qxz - r_sy);
            r_m.m21 <= fin(r_qyz + r_sx);
            r_m.m22 <= fin(r_qzz + r_cd);
        end
    end

    assign o_vld = r_vo;
    assign o_m   = r_m;
endmodule
